@@ design/sal_pkg.sv @@
// shared constants, codes and the probe record for the shelf atlas allocator
`timescale 1ns / 1ps
package sal_pkg;

	localparam int PAGE_WIDTH  = 1024;
	localparam int PAGE_HEIGHT = 1024;
	localparam int NUM_PAGES   = 4;

	localparam int DIM_MAX = (PAGE_WIDTH > PAGE_HEIGHT) ? PAGE_WIDTH : PAGE_HEIGHT;
	localparam int CW      = $clog2(DIM_MAX + 1);
	localparam int SW      = CW + 2;
	localparam int IW      = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;

	localparam logic REQ_RESERVE = 1'b0;
	localparam logic REQ_TOUCH   = 1'b1;

	localparam logic MODE_SCAN  = 1'b0;
	localparam logic MODE_APPLY = 1'b1;

	localparam logic [1:0] ACT_NONE  = 2'd0;
	localparam logic [1:0] ACT_CLAIM = 2'd1;
	localparam logic [1:0] ACT_EVICT = 2'd2;
	localparam logic [1:0] ACT_TOUCH = 2'd3;

	typedef struct packed {
		logic          live;
		logic          mode;
		logic          place;
		logic [CW-1:0] w;
		logic [CW-1:0] h;
		logic [63:0]   tick_next;
		logic          found;
		logic [IW-1:0] page;
		logic [CW-1:0] x;
		logic [CW-1:0] y;
		logic [15:0]   gen;
		logic          has_free;
		logic [IW-1:0] free_idx;
		logic [IW-1:0] lru_idx;
		logic [63:0]   lru_val;
		logic [1:0]    act;
		logic [IW-1:0] target;
	} probe_t;

endpackage

@@ design/sal_ifs.sv @@
// request and result channel interfaces
`timescale 1ns / 1ps
interface sal_req_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [10:0] rect_width;
	logic [10:0] rect_height;
	logic [1:0]  touch_page;

	modport source (output valid, req_type, rect_width, rect_height, touch_page, input ready);
	modport sink (input valid, req_type, rect_width, rect_height, touch_page, output ready);
endinterface

interface sal_res_if;
	logic        valid;
	logic        ready;
	logic        status;
	logic [1:0]  placed_page;
	logic [9:0]  placed_x;
	logic [9:0]  placed_y;
	logic [15:0] page_gen;
	logic        evicted;
	logic [31:0] eviction_total;

	modport source (output valid, status, placed_page, placed_x, placed_y, page_gen, evicted,
		eviction_total, input ready);
	modport sink (input valid, status, placed_page, placed_x, placed_y, page_gen, evicted,
		eviction_total, output ready);
endinterface

@@ design/sal_cell.sv @@
// one page cell: holds a page's shelf state and updates the passing probe
`timescale 1ns / 1ps
module sal_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [sal_pkg::IW-1:0] cell_idx,
	input  sal_pkg::probe_t       probe_in,
	output sal_pkg::probe_t       probe_out
);
	import sal_pkg::*;

	logic          in_use_q;
	logic [15:0]   gen_q;
	logic [CW-1:0] top_q;
	logic [CW-1:0] height_q;
	logic [CW-1:0] fill_q;
	logic [63:0]   stamp_q;
	probe_t        probe_q;
	probe_t        probe_nxt;

	logic [SW-1:0] sum_col;
	logic [SW-1:0] below;
	logic          fits_shelf;
	logic          fits_new;
	logic          scan_live;
	logic          scan_hit;
	logic          apply_hit;

	assign sum_col    = SW'(fill_q) + SW'(probe_in.w);
	assign below      = SW'(top_q) + SW'(height_q);
	assign fits_shelf = (sum_col <= SW'(PAGE_WIDTH)) && (probe_in.h <= height_q);
	assign fits_new   = (below + SW'(probe_in.h)) <= SW'(PAGE_HEIGHT);
	assign scan_live  = probe_in.live && (probe_in.mode == MODE_SCAN);
	assign scan_hit   = scan_live && probe_in.place && in_use_q && !probe_in.found
		&& (fits_shelf || fits_new);
	assign apply_hit  = probe_in.live && (probe_in.mode == MODE_APPLY)
		&& (probe_in.target == cell_idx);

	always_comb begin
		probe_nxt = probe_in;
		if (scan_hit) begin
			probe_nxt.found = 1'b1;
			probe_nxt.page  = cell_idx;
			probe_nxt.gen   = gen_q;
			if (fits_shelf) begin
				probe_nxt.x = fill_q;
				probe_nxt.y = top_q;
			end else begin
				probe_nxt.x = '0;
				probe_nxt.y = CW'(below);
			end
		end
		if (scan_live && !in_use_q && !probe_in.has_free) begin
			probe_nxt.has_free = 1'b1;
			probe_nxt.free_idx = cell_idx;
		end
		if (scan_live && ((cell_idx == '0) || (stamp_q < probe_in.lru_val))) begin
			probe_nxt.lru_idx = cell_idx;
			probe_nxt.lru_val = stamp_q;
		end
		if (apply_hit) begin
			probe_nxt.gen = (probe_in.act == ACT_EVICT) ? gen_q + 16'd1 : gen_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q <= 1'b0;
			gen_q    <= '0;
			top_q    <= '0;
			height_q <= '0;
			fill_q   <= '0;
			stamp_q  <= '0;
			probe_q  <= '0;
		end else begin
			probe_q <= probe_nxt;
			if (scan_hit) begin
				stamp_q <= probe_in.tick_next;
				if (fits_shelf) begin
					fill_q <= CW'(sum_col);
				end else begin
					top_q    <= CW'(below);
					height_q <= probe_in.h;
					fill_q   <= probe_in.w;
				end
			end
			if (apply_hit) begin
				case (probe_in.act)
					ACT_CLAIM: begin
						in_use_q <= 1'b1;
						top_q    <= '0;
						height_q <= probe_in.h;
						fill_q   <= probe_in.w;
						stamp_q  <= probe_in.tick_next;
					end
					ACT_EVICT: begin
						gen_q    <= gen_q + 16'd1;
						top_q    <= '0;
						height_q <= probe_in.h;
						fill_q   <= probe_in.w;
						stamp_q  <= probe_in.tick_next;
					end
					ACT_TOUCH: begin
						stamp_q <= probe_in.tick_next;
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign probe_out = probe_q;
endmodule

@@ design/shelf_atlas_allocator_lru_top.sv @@
// top level: request control, row of page cells and result register
//
// Use: a request on req either reserves a rect_width by rect_height
// rectangle (req_type 0) or marks touch_page as recently used (req_type 1).
// Every request gives exactly one result on res: the page, corner and
// generation of the placement, whether a page was evicted, and the running
// eviction count. A rectangle larger than a page returns status 1.
// A request goes twice along the row of page cells, one cell per cycle:
// a scan pass that places on the first in-use page with room and finds the
// first free page and the least recently used one, then an apply pass that
// claims, evicts or touches the chosen page. A new request can be taken at
// the earliest in the cycle after the result is loaded.
// req.ready is high only between requests. A result waits in the output
// register while res.ready is low; a finished request then holds in its
// last step and no new request is taken until that result moves out.
// Reset empties all pages and clears generations, use ticks and counts.
`timescale 1ns / 1ps
module shelf_atlas_allocator_lru_top (
	input logic clk,
	input logic arst_n,
	sal_req_if.sink   req,
	sal_res_if.source res
);
	import sal_pkg::*;

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_SCAN_GO  = 3'd1;
	localparam logic [2:0] ST_SCAN     = 3'd2;
	localparam logic [2:0] ST_APPLY_GO = 3'd3;
	localparam logic [2:0] ST_APPLY    = 3'd4;
	localparam logic [2:0] ST_DRAIN    = 3'd5;

	logic [2:0]    state_q;
	logic          req_type_q;
	logic          over_q;
	logic          touch_ok_q;
	logic [CW-1:0] w_q;
	logic [CW-1:0] h_q;
	logic [1:0]    touch_q;
	logic [63:0]   tick_next_q;
	logic [63:0]   use_tick_q;
	logic [31:0]   evict_cnt_q;
	logic          found_q;
	logic [IW-1:0] page_q;
	logic [CW-1:0] x_q;
	logic [CW-1:0] y_q;
	logic [15:0]   gen_a_q;
	logic [15:0]   gen_b_q;
	logic [1:0]    act_q;
	logic [IW-1:0] target_q;

	logic          res_valid_q;
	logic          res_status_q;
	logic [1:0]    res_page_q;
	logic [9:0]    res_x_q;
	logic [9:0]    res_y_q;
	logic [15:0]   res_gen_q;
	logic          res_evicted_q;
	logic [31:0]   res_total_q;

	probe_t              link [NUM_PAGES+1];
	probe_t              head;
	logic [NUM_PAGES-1:0] live_vec;
	probe_t              last;
	logic                accept;
	logic                over_now;
	logic                placing;
	logic                load_res;

	logic          r_status;
	logic [1:0]    r_page;
	logic [9:0]    r_x;
	logic [9:0]    r_y;
	logic [15:0]   r_gen;

	assign accept   = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign over_now = ({2'b00, req.rect_width} > 13'(PAGE_WIDTH))
		|| ({2'b00, req.rect_height} > 13'(PAGE_HEIGHT));
	assign placing  = (req_type_q == REQ_RESERVE) && !over_q;
	assign last     = link[NUM_PAGES];
	assign load_res = (state_q == ST_DRAIN) && (!res_valid_q || res.ready);

	always_comb begin
		head           = '0;
		head.live      = (state_q == ST_SCAN_GO) || (state_q == ST_APPLY_GO);
		head.mode      = (state_q == ST_APPLY_GO) ? MODE_APPLY : MODE_SCAN;
		head.place     = placing;
		head.w         = w_q;
		head.h         = h_q;
		head.tick_next = tick_next_q;
		head.act       = act_q;
		head.target    = target_q;
	end

	assign link[0] = head;

	genvar k;
	generate
		for (k = 0; k < NUM_PAGES; k++) begin : g_cell
			sal_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.cell_idx  (IW'(k)),
				.probe_in  (link[k]),
				.probe_out (link[k+1])
			);
			assign live_vec[k] = link[k+1].live;
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			use_tick_q  <= '0;
			evict_cnt_q <= '0;
			act_q       <= ACT_NONE;
			target_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_SCAN_GO;
						act_q   <= ACT_NONE;
					end
				end
				ST_SCAN_GO: begin
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (last.live) begin
						state_q <= ST_APPLY_GO;
						if (req_type_q == REQ_TOUCH ? touch_ok_q : !over_q) begin
							use_tick_q <= tick_next_q;
						end
						if (req_type_q == REQ_TOUCH) begin
							act_q    <= touch_ok_q ? ACT_TOUCH : ACT_NONE;
							target_q <= IW'(touch_q);
						end else if (over_q || last.found) begin
							act_q <= ACT_NONE;
						end else if (last.has_free) begin
							act_q    <= ACT_CLAIM;
							target_q <= last.free_idx;
						end else begin
							act_q       <= ACT_EVICT;
							target_q    <= last.lru_idx;
							evict_cnt_q <= evict_cnt_q + 32'd1;
						end
					end
				end
				ST_APPLY_GO: begin
					state_q <= ST_APPLY;
				end
				ST_APPLY: begin
					if (last.live) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (load_res) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_type_q  <= req.req_type;
			over_q      <= over_now;
			touch_ok_q  <= (int'(req.touch_page) < NUM_PAGES);
			w_q         <= CW'(req.rect_width);
			h_q         <= CW'(req.rect_height);
			touch_q     <= req.touch_page;
			tick_next_q <= use_tick_q + 64'd1;
		end
		if ((state_q == ST_SCAN) && last.live) begin
			found_q <= last.found;
			page_q  <= last.page;
			x_q     <= last.x;
			y_q     <= last.y;
			gen_a_q <= last.gen;
		end
		if ((state_q == ST_APPLY) && last.live) begin
			gen_b_q <= last.gen;
		end
	end

	always_comb begin
		r_status = placing ? 1'b0 : ((req_type_q == REQ_RESERVE) ? 1'b1 : 1'b0);
		r_page   = '0;
		r_x      = '0;
		r_y      = '0;
		r_gen    = '0;
		if (req_type_q == REQ_TOUCH) begin
			r_page = touch_q;
			r_gen  = touch_ok_q ? gen_b_q : 16'd0;
		end else if (!over_q) begin
			if (found_q) begin
				r_page = 2'(page_q);
				r_x    = 10'(x_q);
				r_y    = 10'(y_q);
				r_gen  = gen_a_q;
			end else begin
				r_page = 2'(target_q);
				r_gen  = gen_b_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_res) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			res_status_q  <= r_status;
			res_page_q    <= r_page;
			res_x_q       <= r_x;
			res_y_q       <= r_y;
			res_gen_q     <= r_gen;
			res_evicted_q <= (act_q == ACT_EVICT);
			res_total_q   <= evict_cnt_q;
		end
	end

	assign res.valid          = res_valid_q;
	assign res.status         = res_status_q;
	assign res.placed_page    = res_page_q;
	assign res.placed_x       = res_x_q;
	assign res.placed_y       = res_y_q;
	assign res.page_gen       = res_gen_q;
	assign res.evicted        = res_evicted_q;
	assign res.eviction_total = res_total_q;

	a_one_probe: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(live_vec))
		else $error("more than one probe in the cell row");

	a_idle_row: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> (live_vec == '0))
		else $error("request taken while a probe is in the row");

	a_res_from_drain: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res.valid) |-> ($past(state_q) == ST_DRAIN))
		else $error("result appeared outside the drain step");

	a_evict_count: assert property (@(posedge clk) disable iff (!arst_n)
		(evict_cnt_q != $past(evict_cnt_q)) |-> ($past(state_q) == ST_SCAN))
		else $error("eviction count moved outside the scan return");
endmodule
